@@ hw/rtl/msds_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msds_pkg
// Shared types, opcodes and constants of the MIPS-I subset execute block.
// ----------------------------------------------------------------------------
package msds_pkg;

	// Data path and register file geometry.
	localparam int unsigned DATA_W   = 32;
	localparam int unsigned NUM_REGS = 32;
	localparam int unsigned REG_AW   = $clog2(NUM_REGS);
	localparam int unsigned PHYS_W   = 29;

	// Architectural constants.
	localparam logic [DATA_W-1:0] RESET_PC = 32'hBFC0_0000;
	localparam logic [REG_AW-1:0] REG_ZERO = 5'd0;
	localparam logic [REG_AW-1:0] REG_RA   = 5'd31;

	// Input item kinds, carried on tuser.
	localparam logic KIND_INSTR = 1'b0;
	localparam logic KIND_LOAD  = 1'b1;

	// Memory request codes of a result.
	typedef enum logic [1:0] {
		MEM_NONE  = 2'd0,
		MEM_LOAD  = 2'd1,
		MEM_STORE = 2'd2
	} mem_req_t;

	// Primary opcodes.
	localparam logic [5:0] OP_SPECIAL = 6'h00;
	localparam logic [5:0] OP_J       = 6'h02;
	localparam logic [5:0] OP_JAL     = 6'h03;
	localparam logic [5:0] OP_BEQ     = 6'h04;
	localparam logic [5:0] OP_BNE     = 6'h05;
	localparam logic [5:0] OP_ADDIU   = 6'h09;
	localparam logic [5:0] OP_ORI     = 6'h0D;
	localparam logic [5:0] OP_LUI     = 6'h0F;
	localparam logic [5:0] OP_LW      = 6'h23;
	localparam logic [5:0] OP_SW      = 6'h2B;

	// Function codes of the SPECIAL group.
	localparam logic [5:0] FN_SLL  = 6'h00;
	localparam logic [5:0] FN_SRL  = 6'h02;
	localparam logic [5:0] FN_JR   = 6'h08;
	localparam logic [5:0] FN_ADDU = 6'h21;
	localparam logic [5:0] FN_AND  = 6'h24;
	localparam logic [5:0] FN_OR   = 6'h25;
	localparam logic [5:0] FN_SLT  = 6'h2A;

	// Register file write-back.
	typedef struct packed {
		logic              en;
		logic [REG_AW-1:0] addr;
		logic [DATA_W-1:0] data;
	} wb_t;

	// Architectural state other than the register file.
	typedef struct packed {
		logic [DATA_W-1:0] pc;
		logic [DATA_W-1:0] branch_target;
		logic              delay_pending;
		logic [REG_AW-1:0] load_dest;
		logic              load_waiting;
	} arch_state_t;

	// One result item.
	typedef struct packed {
		logic              load_wait;
		logic [DATA_W-1:0] store_data;
		logic [PHYS_W-1:0] mem_addr;
		mem_req_t          mem_request;
		logic [PHYS_W-1:0] fetch_addr;
	} result_t;

endpackage
`default_nettype wire

@@ hw/rtl/mips_subset_execute_delay_slot.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mips_subset_execute_delay_slot
// Executes a MIPS-I integer subset with one branch delay slot.
//
// Input stream s_axis: tuser is the item kind (instruction word or returning
// load data), tdata carries the instruction word and the load data. Output
// stream m_axis: exactly one result transaction per input transaction, holding
// the next fetch address, the memory request with its address and store data,
// and the load-wait flag.
// An accepted transaction goes to the execute stage register, its result to
// the output register on m_axis. Throughput: one transaction per cycle
// unless m_axis stalls. The register file sits in two synchronous RAMs read at
// acceptance; execute and write-back in the execute stage, last write forwarded.
// Reset: the pc becomes 0xBFC00000, the delay slot and load wait clear, and
// every register reads as zero. No clearing pass is needed.
// Stalls: while m_axis is stalled one result is held and one more item may
// wait in the execute stage; after that s_axis_tready falls.
// ----------------------------------------------------------------------------
module mips_subset_execute_delay_slot
	import msds_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [63:0] s_axis_tdata,  // instr_word[31:0], load_data[63:32]
	input  wire logic        s_axis_tuser,  // kind[0]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// fetch_addr[28:0], mem_request[30:29], mem_addr[59:31],
	// store_data[91:60], load_wait[92], zero fill[95:93]
	output logic      [95:0] m_axis_tdata
);

	logic        in_acc;
	logic        valid_s1;
	logic        s1_fire;
	logic        kind_s1;
	logic [31:0] instr_s1;
	logic [31:0] ldata_s1;
	logic [31:0] rs_data;
	logic [31:0] rt_data;
	arch_state_t state_q;
	arch_state_t state_nxt;
	wb_t         wb_exec;
	wb_t         wb_commit;
	result_t     res_exec;
	result_t     res_q;
	logic        out_valid_q;

	// Handshakes: the execute stage moves when the output register frees up.
	assign s1_fire       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || s1_fire;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	// Register file, read at acceptance with the source fields of the word.
	msds_regfile u_regfile (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_acc),
		.rs_addr (s_axis_tdata[25:21]),
		.rt_addr (s_axis_tdata[20:16]),
		.wb      (wb_commit),
		.rs_data (rs_data),
		.rt_data (rt_data)
	);

	// Execute stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			kind_s1  <= s_axis_tuser;
			instr_s1 <= s_axis_tdata[31:0];
			ldata_s1 <= s_axis_tdata[63:32];
		end
	end

	// Decode and execute.
	msds_exec u_exec (
		.kind  (kind_s1),
		.instr (instr_s1),
		.ldata (ldata_s1),
		.a     (rs_data),
		.b     (rt_data),
		.cur   (state_q),
		.nxt   (state_nxt),
		.wb    (wb_exec),
		.res   (res_exec)
	);

	// Write-back only when the item leaves the execute stage.
	always_comb begin
		wb_commit    = wb_exec;
		wb_commit.en = wb_exec.en && s1_fire;
	end

	// Architectural state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{pc: RESET_PC, branch_target: '0, delay_pending: 1'b0,
				load_dest: '0, load_waiting: 1'b0};
		end else if (s1_fire) begin
			state_q <= state_nxt;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			res_q <= res_exec;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'd0, res_q};

	// A load request always leaves the block waiting for its data.
	a_load_waits: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.mem_request == MEM_LOAD |-> res_q.load_wait)
		else $error("load request issued without load wait");

	// Address and store data are zero when no memory request is made.
	a_idle_bus: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.mem_request == MEM_NONE
		|-> res_q.mem_addr == '0 && res_q.store_data == '0)
		else $error("memory fields set without a request");

	// No store is issued while a load is outstanding.
	a_no_store_while_wait: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && state_q.load_waiting |-> res_exec.mem_request == MEM_NONE)
		else $error("memory request issued while waiting for load data");

	// An item held in the execute stage keeps its contents.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_fire |=> valid_s1 && $stable(instr_s1) && $stable(kind_s1))
		else $error("execute stage changed while stalled");

endmodule
`default_nettype wire

@@ hw/rtl/msds_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msds_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module msds_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port; returns the old contents on a same-address write.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/msds_regfile.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msds_regfile
// General register file held in two RAM copies, one per source operand, with
// per-entry valid bits for the reset value and forwarding of the last write.
// ----------------------------------------------------------------------------
module msds_regfile
	import msds_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              rd_en,
	input  wire logic [REG_AW-1:0] rs_addr,
	input  wire logic [REG_AW-1:0] rt_addr,
	input  wire wb_t               wb,
	output logic      [DATA_W-1:0] rs_data,
	output logic      [DATA_W-1:0] rt_data
);

	logic [REG_AW-1:0]   rs_addr_q;
	logic [REG_AW-1:0]   rt_addr_q;
	logic [NUM_REGS-1:0] valid_q;
	wb_t                 wb_q;
	logic [DATA_W-1:0]   rs_ram;
	logic [DATA_W-1:0]   rt_ram;

	// Both copies take every write; each serves one operand.
	msds_ram #(.WIDTH(DATA_W), .DEPTH(NUM_REGS)) u_rs_ram (
		.clk   (clk),
		.we    (wb.en),
		.waddr (wb.addr),
		.wdata (wb.data),
		.re    (rd_en),
		.raddr (rs_addr),
		.rdata (rs_ram)
	);

	msds_ram #(.WIDTH(DATA_W), .DEPTH(NUM_REGS)) u_rt_ram (
		.clk   (clk),
		.we    (wb.en),
		.waddr (wb.addr),
		.wdata (wb.data),
		.re    (rd_en),
		.raddr (rt_addr),
		.rdata (rt_ram)
	);

	// Read addresses follow the RAM read, so the operand can be resolved later.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rs_addr_q <= '0;
			rt_addr_q <= '0;
		end else if (rd_en) begin
			rs_addr_q <= rs_addr;
			rt_addr_q <= rt_addr;
		end
	end

	// Valid bits stand in for the all-zero reset of the RAM contents.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wb.en) begin
			valid_q[wb.addr] <= 1'b1;
		end
	end

	// The most recent write, which a read in the same cycle did not see.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wb_q <= '0;
		end else if (wb.en || rd_en) begin
			wb_q <= wb;
		end
	end

	// Operand selection: forwarded write, then stored value, then reset value.
	always_comb begin
		if (wb_q.en && wb_q.addr == rs_addr_q) begin
			rs_data = wb_q.data;
		end else if (valid_q[rs_addr_q]) begin
			rs_data = rs_ram;
		end else begin
			rs_data = '0;
		end
		if (wb_q.en && wb_q.addr == rt_addr_q) begin
			rt_data = wb_q.data;
		end else if (valid_q[rt_addr_q]) begin
			rt_data = rt_ram;
		end else begin
			rt_data = '0;
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/msds_exec.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msds_exec
// Decode and execute of one item: computes the register write-back, the next
// pc and delay-slot state, the load wait and the memory request.
// ----------------------------------------------------------------------------
module msds_exec
	import msds_pkg::*;
(
	input  wire logic        kind,
	input  wire logic [31:0] instr,
	input  wire logic [31:0] ldata,
	input  wire logic [31:0] a,
	input  wire logic [31:0] b,
	input  wire arch_state_t cur,
	output arch_state_t      nxt,
	output wb_t              wb,
	output result_t          res
);

	logic [5:0]  primary;
	logic [5:0]  fn;
	logic [4:0]  rt;
	logic [4:0]  rd;
	logic [4:0]  sh;
	logic [15:0] imm;
	logic [31:0] simm;
	logic [31:0] pc4;
	logic [31:0] jtgt;
	logic [31:0] btgt;
	logic [31:0] addsum;

	// Field extraction and address arithmetic.
	always_comb begin
		primary = instr[31:26];
		rt      = instr[20:16];
		rd      = instr[15:11];
		sh      = instr[10:6];
		fn      = instr[5:0];
		imm     = instr[15:0];
		simm    = {{16{imm[15]}}, imm};
		pc4     = cur.pc + 32'd4;
		jtgt    = {pc4[31:28], instr[25:0], 2'b00};
		btgt    = pc4 + {simm[29:0], 2'b00};
		addsum  = a + simm;
	end

	// Execute.
	always_comb begin
		nxt             = cur;
		wb              = '0;
		res             = '0;
		res.mem_request = MEM_NONE;
		if (kind == KIND_LOAD) begin
			if (cur.load_waiting) begin
				wb.en            = cur.load_dest != REG_ZERO;
				wb.addr          = cur.load_dest;
				wb.data          = ldata;
				nxt.load_waiting = 1'b0;
			end
		end else if (!cur.load_waiting) begin
			nxt.delay_pending = 1'b0;
			wb.addr           = rd;
			unique case (primary)
				OP_SPECIAL: begin
					unique case (fn)
						FN_SLL:  begin wb.en = 1'b1; wb.data = b << sh; end
						FN_SRL:  begin wb.en = 1'b1; wb.data = b >> sh; end
						FN_ADDU: begin wb.en = 1'b1; wb.data = a + b; end
						FN_AND:  begin wb.en = 1'b1; wb.data = a & b; end
						FN_OR:   begin wb.en = 1'b1; wb.data = a | b; end
						FN_SLT:  begin
							wb.en   = 1'b1;
							wb.data = {31'd0, $signed(a) < $signed(b)};
						end
						FN_JR: begin
							nxt.branch_target = a;
							nxt.delay_pending = 1'b1;
						end
						default: ;
					endcase
				end
				OP_J: begin
					nxt.branch_target = jtgt;
					nxt.delay_pending = 1'b1;
				end
				OP_JAL: begin
					wb.en             = 1'b1;
					wb.addr           = REG_RA;
					wb.data           = cur.pc + 32'd8;
					nxt.branch_target = jtgt;
					nxt.delay_pending = 1'b1;
				end
				OP_BEQ: begin
					if (a == b) begin
						nxt.branch_target = btgt;
						nxt.delay_pending = 1'b1;
					end
				end
				OP_BNE: begin
					if (a != b) begin
						nxt.branch_target = btgt;
						nxt.delay_pending = 1'b1;
					end
				end
				OP_ADDIU: begin wb.en = 1'b1; wb.addr = rt; wb.data = addsum; end
				OP_ORI: begin
					wb.en   = 1'b1;
					wb.addr = rt;
					wb.data = a | {16'd0, imm};
				end
				OP_LUI: begin wb.en = 1'b1; wb.addr = rt; wb.data = {imm, 16'd0}; end
				OP_LW: begin
					res.mem_request  = MEM_LOAD;
					res.mem_addr     = addsum[PHYS_W-1:0];
					nxt.load_dest    = rt;
					nxt.load_waiting = 1'b1;
				end
				OP_SW: begin
					res.mem_request = MEM_STORE;
					res.mem_addr    = addsum[PHYS_W-1:0];
					res.store_data  = b;
				end
				default: ;
			endcase
			// Register zero is never written.
			if (wb.addr == REG_ZERO) begin
				wb.en = 1'b0;
			end
			// The delay slot hands over to the latest recorded target.
			nxt.pc = cur.delay_pending ? nxt.branch_target : pc4;
		end
		res.fetch_addr = nxt.pc[PHYS_W-1:0];
		res.load_wait  = nxt.load_waiting;
	end

endmodule
`default_nettype wire
